FILE: hdl/cwh_pkg.sv
// Package for the three-way cuckoo hash table unit.
// Operation and status codes, register indexes, defaults and the
// command/status structs between controller and datapath. No dependencies.
package cwh_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IN_W  = 72;   // op, key_in, value_in, padded to 9 bytes
    localparam int OUT_W = 112;  // 14 bytes, no padding
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED   = 3'd0;
    localparam logic [2:0] ST_DUPLICATE  = 3'd1;
    localparam logic [2:0] ST_INS_FAILED = 3'd2;
    localparam logic [2:0] ST_FOUND      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_REMOVED    = 3'd5;
    localparam logic [2:0] ST_REMOVE_MISS = 3'd6;
    // internal only, never leaves the unit
    localparam logic [2:0] ST_EVICTING   = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_THIRD  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ROUNDS   = 8'd4;

    localparam logic [4:0]  RST_SHIFT_FIRST  = 5'd1;
    localparam logic [4:0]  RST_SHIFT_SECOND = 5'd2;
    localparam logic [4:0]  RST_SHIFT_THIRD  = 5'd3;
    localparam logic [10:0] RST_SLOTS_IN_USE = 11'd17;
    localparam logic [7:0]  RST_MAX_ROUNDS   = 8'd99;

    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       hash_start;
        logic       rd;
        logic       do_remove;
        logic       ev_place;
        logic       ev_swap;
        logic       out_load;
        logic [2:0] status;
    } cwh_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       hash_busy;
        logic [1:0] op;
        logic       hit;
        logic       slot_full;
        logic       last_swap;
        logic       zero_rounds;
    } cwh_stat_t;

endpackage

FILE: hdl/cwh_hash.sv
// Bit-serial hash unit: (key << shift_t) mod m for all three tables at once.
// Depends on nothing but its parameters.
module cwh_hash #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [KEY_WIDTH-1:0]           key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] modulus,
    input  logic [4:0]                     shift0,
    input  logic [4:0]                     shift1,
    input  logic [4:0]                     shift2,
    output logic                           busy,
    output logic [$clog2(TABLE_DEPTH)-1:0] h0,
    output logic [$clog2(TABLE_DEPTH)-1:0] h1,
    output logic [$clog2(TABLE_DEPTH)-1:0] h2
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(KEY_WIDTH + 32);

    logic                 busy_reg;
    logic [SW-1:0]        step_reg;
    logic [KEY_WIDTH-1:0] ksh_reg;
    logic [IW-1:0]        r_reg, r_next;
    logic [IW-1:0]        h0_reg, h1_reg, h2_reg;
    logic                 phase_b, in_bit;
    logic [4:0]           k;
    logic [IW+1:0]        trial;

    assign phase_b = (step_reg >= SW'(KEY_WIDTH));
    assign k       = 5'(step_reg - SW'(KEY_WIDTH));
    assign in_bit  = phase_b ? 1'b0 : ksh_reg[KEY_WIDTH-1];

    // one restoring step: trial < 2m, so a single subtract suffices
    always_comb begin
        trial = {1'b0, r_reg, in_bit};
        if (trial >= (IW+2)'(modulus)) begin
            r_next = IW'(trial - (IW+2)'(modulus));
        end else begin
            r_next = IW'(trial);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg == SW'(KEY_WIDTH + 31)) begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ksh_reg <= key;
            r_reg   <= '0;
        end else if (busy_reg) begin
            ksh_reg <= ksh_reg << 1;
            r_reg   <= r_next;
            // r holds (key << k) mod m here
            if (phase_b && k == shift0) h0_reg <= r_reg;
            if (phase_b && k == shift1) h1_reg <= r_reg;
            if (phase_b && k == shift2) h2_reg <= r_reg;
        end
    end

    assign busy = busy_reg;
    assign h0   = h0_reg;
    assign h1   = h1_reg;
    assign h2   = h2_reg;
endmodule

FILE: hdl/cwh_datapath.sv
// Datapath: slot memories, valid memories, counters, item and result registers.
// Depends on cwh_pkg and cwh_hash.
module cwh_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cwh_pkg::cwh_cmd_t         cmd,
    output cwh_pkg::cwh_stat_t        stat,
    input  logic [cwh_pkg::IN_W-1:0]  in_data,
    input  logic [4:0]                shift_first,
    input  logic [4:0]                shift_second,
    input  logic [4:0]                shift_third,
    input  logic [10:0]               slots_in_use,
    input  logic [7:0]                max_rounds,
    output logic [cwh_pkg::OUT_W-1:0] out_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int MW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = IW + 1;

    logic [MW-1:0]          modulus;
    logic [31:0]            slots32;
    logic [IW-1:0]          h [3];
    logic                   hash_busy;
    logic [IW-1:0]          clr_cnt_reg;
    logic [1:0]             op_reg;
    logic [KEY_WIDTH-1:0]   ck_reg;
    logic [VALUE_WIDTH-1:0] cv_reg;
    logic [1:0]             u_reg;
    logic [7:0]             round_reg;
    logic [CW-1:0]          cnt_reg [3];
    logic [KEY_WIDTH-1:0]   rd_key [3];
    logic [VALUE_WIDTH-1:0] rd_val [3];
    logic                   rd_vld [3];
    logic                   hit;
    logic [1:0]             hit_tbl;
    logic [KEY_WIDTH-1:0]   u_key;
    logic [VALUE_WIDTH-1:0] u_val, hit_val;
    logic [CW+1:0]          total;
    logic [cwh_pkg::OUT_W-1:0] out_reg;

    assign slots32 = 32'(slots_in_use);
    always_comb begin
        if (slots32 < 32'd2) begin
            modulus = MW'(2);
        end else if (slots32 > 32'(TABLE_DEPTH)) begin
            modulus = MW'(TABLE_DEPTH);
        end else begin
            modulus = MW'(slots32);
        end
    end

    cwh_hash #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.hash_start),
        .key    (ck_reg),
        .modulus(modulus),
        .shift0 (shift_first),
        .shift1 (shift_second),
        .shift2 (shift_third),
        .busy   (hash_busy),
        .h0     (h[0]),
        .h1     (h[1]),
        .h2     (h[2])
    );

    for (genvar g = 0; g < 3; g++) begin : g_tbl
        logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
        logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];
        logic                   vld_mem [TABLE_DEPTH];
        logic                   wr_pair;

        assign wr_pair = (cmd.ev_place || cmd.ev_swap) && u_reg == 2'(g);

        always_ff @(posedge aclk) begin
            if (cmd.clr_step) begin
                vld_mem[clr_cnt_reg] <= 1'b0;
            end else if (cmd.do_remove && hit_tbl == 2'(g)) begin
                vld_mem[h[g]] <= 1'b0;
            end else if (wr_pair) begin
                vld_mem[h[g]] <= 1'b1;
            end
            if (wr_pair) begin
                key_mem[h[g]] <= ck_reg;
                val_mem[h[g]] <= cv_reg;
            end
            if (cmd.rd) begin
                rd_key[g] <= key_mem[h[g]];
                rd_val[g] <= val_mem[h[g]];
                rd_vld[g] <= vld_mem[h[g]];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cnt_reg[g] <= '0;
            end else if (cmd.do_remove && hit_tbl == 2'(g)) begin
                cnt_reg[g] <= cnt_reg[g] - 1'b1;
            end else if (cmd.ev_place && u_reg == 2'(g)) begin
                cnt_reg[g] <= cnt_reg[g] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // first table, in order, holding the key
    always_comb begin
        hit     = 1'b1;
        hit_tbl = 2'd0;
        if (rd_vld[0] && rd_key[0] == ck_reg) begin
            hit_tbl = 2'd0;
        end else if (rd_vld[1] && rd_key[1] == ck_reg) begin
            hit_tbl = 2'd1;
        end else if (rd_vld[2] && rd_key[2] == ck_reg) begin
            hit_tbl = 2'd2;
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        unique case (u_reg)
            2'd1:    begin u_key = rd_key[1]; u_val = rd_val[1]; end
            2'd2:    begin u_key = rd_key[2]; u_val = rd_val[2]; end
            default: begin u_key = rd_key[0]; u_val = rd_val[0]; end
        endcase
        unique case (hit_tbl)
            2'd1:    hit_val = rd_val[1];
            2'd2:    hit_val = rd_val[2];
            default: hit_val = rd_val[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= in_data[1:0];
            ck_reg    <= in_data[KEY_WIDTH+1:2];
            cv_reg    <= VALUE_WIDTH'(in_data[65:34]);
            u_reg     <= 2'd0;
            round_reg <= 8'd0;
        end else if (cmd.ev_swap) begin
            ck_reg <= u_key;
            cv_reg <= u_val;
            if (u_reg == 2'd2) begin
                u_reg     <= 2'd0;
                round_reg <= round_reg + 1'b1;
            end else begin
                u_reg <= u_reg + 1'b1;
            end
        end
    end

    assign total = (CW+2)'(cnt_reg[0]) + (CW+2)'(cnt_reg[1]) + (CW+2)'(cnt_reg[2]);

    always_ff @(posedge aclk) begin
        logic [63:0] fv64, ev64;
        fv64 = 64'(hit_val);
        ev64 = 64'(cv_reg);
        if (cmd.out_load) begin
            out_reg[2:0]   <= cmd.status;
            out_reg[34:3]  <= (cmd.status == cwh_pkg::ST_FOUND) ? fv64[31:0] : 32'd0;
            out_reg[66:35] <= (cmd.status == cwh_pkg::ST_INS_FAILED) ? 32'(ck_reg) : 32'd0;
            out_reg[98:67] <= (cmd.status == cwh_pkg::ST_INS_FAILED) ? ev64[31:0] : 32'd0;
            out_reg[110:99] <= 12'(total);
            out_reg[111]   <= (total == '0);
        end
    end

    assign out_data = out_reg;

    assign stat.clear_done  = (clr_cnt_reg == IW'(TABLE_DEPTH - 1));
    assign stat.hash_busy   = hash_busy;
    assign stat.op          = op_reg;
    assign stat.hit         = hit;
    assign stat.slot_full   = (u_reg == 2'd0) ? rd_vld[0] :
                              (u_reg == 2'd1) ? rd_vld[1] : rd_vld[2];
    assign stat.last_swap   = (u_reg == 2'd2) && (9'(round_reg) + 9'd1 == 9'(max_rounds));
    assign stat.zero_rounds = (max_rounds == 8'd0);
endmodule

FILE: hdl/cwh_ctrl.sv
// Controller: sequences clearing, hashing, probing, eviction and result hand-off.
// Depends on cwh_pkg.
module cwh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  cwh_pkg::cwh_stat_t  stat,
    output cwh_pkg::cwh_cmd_t   cmd
);
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HSTART = 3'd2;
    localparam logic [2:0] S_HWAIT  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_EVAL   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] status_reg, status_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_HSTART;
                end
            end
            S_HSTART: begin
                cmd.hash_start = 1'b1;
                state_next     = S_HWAIT;
            end
            S_HWAIT: begin
                if (!stat.hash_busy) state_next = S_READ;
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = (stat.op == cwh_pkg::OP_INSERT &&
                              status_reg == cwh_pkg::ST_EVICTING) ? S_EVAL : S_CHECK;
            end
            S_CHECK: begin
                state_next = S_FINISH;
                priority if (stat.op == cwh_pkg::OP_INSERT) begin
                    if (stat.hit) begin
                        status_next = cwh_pkg::ST_DUPLICATE;
                    end else if (stat.zero_rounds) begin
                        status_next = cwh_pkg::ST_INS_FAILED;
                    end else begin
                        status_next = cwh_pkg::ST_EVICTING;
                        state_next  = S_EVAL;
                    end
                end else if (stat.op == cwh_pkg::OP_REMOVE) begin
                    cmd.do_remove = stat.hit;
                    status_next   = stat.hit ? cwh_pkg::ST_REMOVED
                                             : cwh_pkg::ST_REMOVE_MISS;
                end else begin
                    status_next = stat.hit ? cwh_pkg::ST_FOUND : cwh_pkg::ST_NOT_FOUND;
                end
            end
            S_EVAL: begin
                if (!stat.slot_full) begin
                    cmd.ev_place = 1'b1;
                    status_next  = cwh_pkg::ST_INSERTED;
                    state_next   = S_FINISH;
                end else begin
                    cmd.ev_swap = 1'b1;
                    if (stat.last_swap) begin
                        status_next = cwh_pkg::ST_INS_FAILED;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_HSTART;
                    end
                end
            end
            S_FINISH: begin
                cmd.status = status_reg;
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            status_reg <= cwh_pkg::ST_INSERTED;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
endmodule

FILE: hdl/three_way_cuckoo_hash_table_unit.sv
// Three-way cuckoo hash table; one item at a time. The controller waits on the
// bit-serial hash unit for every lookup and again for every eviction round step.
// Reset: synchronous, active low; a clearing pass over every slot
// empties the valid memories before the first item is accepted.
module three_way_cuckoo_hash_table_unit #(
    parameter int TABLE_DEPTH = cwh_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = cwh_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = cwh_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cwh_pkg::IN_W-1:0]        s_tdata,   // op[1:0], key_in[33:2], value_in[65:34]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cwh_pkg::OUT_W-1:0]       m_tdata,   // status[2:0], found_value[34:3],
                                                       // evicted_key[66:35], evicted_value[98:67],
                                                       // entry_count[110:99], is_empty[111]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cwh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cwh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    cwh_pkg::cwh_cmd_t  cmd;
    cwh_pkg::cwh_stat_t stat;
    logic [4:0]  sh0_reg, sh1_reg, sh2_reg;
    logic [10:0] slots_reg;
    logic [7:0]  rounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh0_reg    <= cwh_pkg::RST_SHIFT_FIRST;
            sh1_reg    <= cwh_pkg::RST_SHIFT_SECOND;
            sh2_reg    <= cwh_pkg::RST_SHIFT_THIRD;
            slots_reg  <= cwh_pkg::RST_SLOTS_IN_USE;
            rounds_reg <= cwh_pkg::RST_MAX_ROUNDS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cwh_pkg::CFG_SHIFT_FIRST:  sh0_reg    <= cfg_data[4:0];
                cwh_pkg::CFG_SHIFT_SECOND: sh1_reg    <= cfg_data[4:0];
                cwh_pkg::CFG_SHIFT_THIRD:  sh2_reg    <= cfg_data[4:0];
                cwh_pkg::CFG_SLOTS_IN_USE: slots_reg  <= cfg_data[10:0];
                cwh_pkg::CFG_MAX_ROUNDS:   rounds_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cwh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cwh_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (s_tdata),
        .shift_first (sh0_reg),
        .shift_second(sh1_reg),
        .shift_third (sh2_reg),
        .slots_in_use(slots_reg),
        .max_rounds  (rounds_reg),
        .out_data    (m_tdata)
    );
endmodule

FILE: hdl/cwh_checker.sv
// Port-level checks for the cuckoo hash table unit, bound to the top level.
// Depends on cwh_pkg.
module cwh_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [cwh_pkg::OUT_W-1:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[111] == (m_tdata[110:99] == 12'd0)))
        else $error("is_empty disagrees with entry_count");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != cwh_pkg::ST_EVICTING)
        else $error("status code out of range");

    a_fval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != cwh_pkg::ST_FOUND |-> m_tdata[34:3] == 32'd0)
        else $error("found_value set without a hit");

    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != cwh_pkg::ST_INS_FAILED |-> m_tdata[98:35] == 64'd0)
        else $error("evicted pair set without a failed insert");
endmodule

bind three_way_cuckoo_hash_table_unit cwh_checker u_cwh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: tb/tb.sv
// Self-checking testbench for three_way_cuckoo_hash_table_unit.
// Random and directed insert/find/remove items, with a table predictor and
// random idling. Depends on cwh_pkg and the unit itself.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [31:0] evicted_key;
        logic [31:0] evicted_value;
        logic [11:0] entry_count;
        logic        is_empty;
    } table_result_t;

    localparam int DEPTH = cwh_pkg::DEF_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 200000;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [cwh_pkg::IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [cwh_pkg::OUT_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [cwh_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cwh_pkg::CFG_DATA_W-1:0] cfg_data;

    three_way_cuckoo_hash_table_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [4:0]  hash_shift[3];
    logic [10:0] slot_limit;
    logic [7:0]  round_limit;
    logic [31:0] slot_key[3][DEPTH];
    logic [31:0] slot_val[3][DEPTH];
    logic        slot_vld[3][DEPTH];
    int          table_fill[3];

    table_result_t expected_q[$];
    logic [cwh_pkg::IN_W-1:0] pending_q[$];
    logic [31:0] key_pool[48];

    int errors = 0;
    int n_predicted = 0;
    int n_checked = 0;
    bit burst_mode = 0;
    bit long_hold_req = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int slot_of_key(int t, logic [31:0] k);
        logic [63:0] w;
        int m;
        m = slot_limit;
        if (m < 2) m = 2;
        if (m > DEPTH) m = DEPTH;
        w = {32'b0, k} << hash_shift[t];
        return int'(w % 64'(m));
    endfunction

    task automatic predict_item(logic [cwh_pkg::IN_W-1:0] d);
        logic [1:0]  op;
        logic [31:0] k, v, ck, cv, tk, tv;
        table_result_t r;
        int hit_t, hit_i, i, total;
        bit placed;
        op = d[1:0];
        k = d[33:2];
        v = d[65:34];
        r.status = cwh_pkg::ST_INSERTED;
        r.found_value = '0;
        r.evicted_key = '0;
        r.evicted_value = '0;
        hit_t = 3;
        hit_i = 0;
        for (int t = 0; t < 3; t++) begin
            i = slot_of_key(t, k);
            if (hit_t == 3 && slot_vld[t][i] && slot_key[t][i] == k) begin
                hit_t = t;
                hit_i = i;
            end
        end
        if (op == cwh_pkg::OP_INSERT) begin
            if (hit_t < 3) begin
                r.status = cwh_pkg::ST_DUPLICATE;
            end else begin
                ck = k;
                cv = v;
                placed = 0;
                for (int rd = 0; rd < round_limit && !placed; rd++) begin
                    for (int u = 0; u < 3 && !placed; u++) begin
                        i = slot_of_key(u, ck);
                        if (!slot_vld[u][i]) begin
                            slot_vld[u][i] = 1;
                            slot_key[u][i] = ck;
                            slot_val[u][i] = cv;
                            table_fill[u]++;
                            placed = 1;
                        end else begin
                            tk = slot_key[u][i];
                            tv = slot_val[u][i];
                            slot_key[u][i] = ck;
                            slot_val[u][i] = cv;
                            ck = tk;
                            cv = tv;
                        end
                    end
                end
                if (!placed) begin
                    r.status = cwh_pkg::ST_INS_FAILED;
                    r.evicted_key = ck;
                    r.evicted_value = cv;
                end
            end
        end else if (op == cwh_pkg::OP_REMOVE) begin
            if (hit_t < 3) begin
                slot_vld[hit_t][hit_i] = 0;
                table_fill[hit_t]--;
                r.status = cwh_pkg::ST_REMOVED;
            end else begin
                r.status = cwh_pkg::ST_REMOVE_MISS;
            end
        end else begin
            // unused op code behaves as a lookup
            if (hit_t < 3) begin
                r.status = cwh_pkg::ST_FOUND;
                r.found_value = slot_val[hit_t][hit_i];
            end else begin
                r.status = cwh_pkg::ST_NOT_FOUND;
            end
        end
        total = table_fill[0] + table_fill[1] + table_fill[2];
        r.entry_count = 12'(total);
        r.is_empty = (total == 0);
        expected_q.push_back(r);
        n_predicted++;
    endtask

    task automatic check_result(logic [cwh_pkg::OUT_W-1:0] d);
        table_result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, d);
            errors++;
        end else begin
            e = expected_q.pop_front();
            if (d[2:0] !== e.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, e.status, d[2:0]);
                errors++;
            end
            if (d[34:3] !== e.found_value) begin
                $display("%0t: found_value exp %h got %h", $realtime, e.found_value, d[34:3]);
                errors++;
            end
            if (d[66:35] !== e.evicted_key) begin
                $display("%0t: evicted_key exp %h got %h", $realtime, e.evicted_key, d[66:35]);
                errors++;
            end
            if (d[98:67] !== e.evicted_value) begin
                $display("%0t: evicted_value exp %h got %h", $realtime, e.evicted_value,
                         d[98:67]);
                errors++;
            end
            if (d[110:99] !== e.entry_count) begin
                $display("%0t: entry_count exp %0d got %0d", $realtime, e.entry_count,
                         d[110:99]);
                errors++;
            end
            if (d[111] !== e.is_empty) begin
                $display("%0t: is_empty exp %0d got %0d", $realtime, e.is_empty, d[111]);
                errors++;
            end
        end
        n_checked++;
    endtask

    // item driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) predict_item(s_tdata);
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_tdata <= pending_q.pop_front();
                s_tvalid <= 1'b1;
                send_gap = burst_mode ? 0 : $urandom_range(0, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    int recv_stall = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready && !burst_mode) recv_stall = $urandom_range(0, 8);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        pending_q.push_back({6'b0, v, k, op});
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || n_predicted != n_checked)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // upper data bits are random to exercise masking; one write to an unknown index
    task automatic write_regs(int s1, int s2, int s3, int slots, int rounds);
        logic [cwh_pkg::CFG_INDEX_W-1:0] idx[6];
        logic [cwh_pkg::CFG_DATA_W-1:0] dat[6];
        idx = '{cwh_pkg::CFG_SHIFT_FIRST, cwh_pkg::CFG_SHIFT_SECOND,
                cwh_pkg::CFG_SHIFT_THIRD, cwh_pkg::CFG_SLOTS_IN_USE,
                cwh_pkg::CFG_MAX_ROUNDS, 8'($urandom_range(5, 255))};
        dat[0] = {11'($urandom), 5'(s1)};
        dat[1] = {11'($urandom), 5'(s2)};
        dat[2] = {11'($urandom), 5'(s3)};
        dat[3] = {5'($urandom), 11'(slots)};
        dat[4] = {8'($urandom), 8'(rounds)};
        dat[5] = 16'($urandom);
        for (int n = 0; n < 6; n++) begin
            cfg_index <= idx[n];
            cfg_data <= dat[n];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            case (idx[n])
                cwh_pkg::CFG_SHIFT_FIRST:  hash_shift[0] = dat[n][4:0];
                cwh_pkg::CFG_SHIFT_SECOND: hash_shift[1] = dat[n][4:0];
                cwh_pkg::CFG_SHIFT_THIRD:  hash_shift[2] = dat[n][4:0];
                cwh_pkg::CFG_SLOTS_IN_USE: slot_limit = dat[n][10:0];
                cwh_pkg::CFG_MAX_ROUNDS:   round_limit = dat[n][7:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int count);
        int r;
        logic [1:0] op;
        logic [31:0] k, v;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? cwh_pkg::OP_INSERT :
                 (r < 72) ? cwh_pkg::OP_FIND :
                 (r < 95) ? cwh_pkg::OP_REMOVE : 2'd3;
            k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 47)] : $urandom;
            r = $urandom_range(0, 9);
            v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            queue_item(op, k, v);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hash_shift = '{cwh_pkg::RST_SHIFT_FIRST, cwh_pkg::RST_SHIFT_SECOND,
                       cwh_pkg::RST_SHIFT_THIRD};
        slot_limit = cwh_pkg::RST_SLOTS_IN_USE;
        round_limit = cwh_pkg::RST_MAX_ROUNDS;
        for (int t = 0; t < 3; t++) begin
            table_fill[t] = 0;
            for (int i = 0; i < DEPTH; i++) slot_vld[t][i] = 0;
        end
        for (int i = 0; i < 48; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset settings; 0, 17, 34, 51 share every slot
        queue_item(cwh_pkg::OP_FIND, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_REMOVE, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_INSERT, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(cwh_pkg::OP_INSERT, 32'h0, 32'h1234_5678);
        queue_item(cwh_pkg::OP_FIND, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_FIND, 32'hFFFF_FFFF, 32'h0);
        queue_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(2'd3, 32'h5, 32'h0);
        queue_item(cwh_pkg::OP_INSERT, 32'd17, 32'hAAAA_AAAA);
        queue_item(cwh_pkg::OP_INSERT, 32'd34, 32'h5555_5555);
        queue_item(cwh_pkg::OP_INSERT, 32'd51, 32'hDEAD_BEEF);
        queue_item(cwh_pkg::OP_FIND, 32'd17, 32'h0);
        queue_item(cwh_pkg::OP_FIND, 32'd34, 32'h0);
        queue_item(cwh_pkg::OP_FIND, 32'd51, 32'h0);
        queue_item(cwh_pkg::OP_FIND, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_REMOVE, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_REMOVE, 32'h0, 32'h0);
        queue_item(cwh_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        queue_item(cwh_pkg::OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_item(cwh_pkg::OP_FIND, 32'h5555_5555, 32'h0);
        wait_drained();

        write_regs(0, 1, 2, 2, 0);        // zero rounds: every new key fails
        queue_item(cwh_pkg::OP_INSERT, 32'h7777_0000, 32'h1);
        random_items(30);
        wait_drained();

        burst_mode = 1;
        write_regs(5, 7, 9, 0, 3);        // capacity below minimum
        random_items(100);
        wait_drained();

        burst_mode = 0;
        write_regs(31, 0, 17, 2047, 2);   // capacity above maximum
        random_items(100);
        wait_drained();

        write_regs(1, 2, 3, 13, 1);
        long_hold_req = 1;
        random_items(150);
        wait_drained();

        write_regs(4, 0, 1, 1024, 255);
        random_items(40);
        wait_drained();

        write_regs(3, 11, 29, 97, 8);
        random_items(200);
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/cwh_pkg.sv
hdl/cwh_hash.sv
hdl/cwh_datapath.sv
hdl/cwh_ctrl.sv
hdl/three_way_cuckoo_hash_table_unit.sv
hdl/cwh_checker.sv
tb/tb.sv
